// ===== design/pla_pkg.sv =====
package pla_pkg;

  localparam int FW           = 32;
  localparam int DIFW         = FW + 1;
  localparam int SQW          = 2 * FW;
  localparam int PRW          = 2 * SQW;
  localparam int EW           = PRW + 3;
  localparam int SQ_STEPS     = (EW + 1) / 2;
  localparam int RW           = SQW + 1;
  localparam int NW           = RW + 1;
  localparam int NORM_BITS    = 30;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int CW           = FW + 2;
  localparam int MW           = FW;
  localparam int KW           = 32;
  localparam int PW           = NORM_BITS + KW;
  localparam int DIV_SHIFT    = 16;
  localparam int QW           = 15;
  localparam int DVW          = PW + 4;
  localparam int DIV_LAT      = QW + 2;
  localparam int SIDE_LAT     = NORM_STEPS + CORDIC_STEPS + 1 + DIV_LAT;
  localparam int OW           = 16;

  localparam logic signed [OW-1:0] ONE_Q14       = 16'sd16384;
  localparam logic [FW-1:0]        GRAVITY_RESET = 32'd642253;

  typedef struct packed {
    logic signed [FW-1:0] from_x;
    logic signed [FW-1:0] from_y;
    logic signed [FW-1:0] to_x;
    logic signed [FW-1:0] to_y;
    logic [FW-1:0]        launch_speed;
  } pla_in_t;

  typedef struct packed {
    logic                 reachable;
    logic signed [OW-1:0] low_cos;
    logic signed [OW-1:0] low_sin;
    logic signed [OW-1:0] high_cos;
    logic signed [OW-1:0] high_sin;
  } pla_out_t;

  typedef struct packed {
    logic valid;
    logic ok;
    logic xneg;
    logic swap;
  } pla_ctl_t;

  typedef struct packed {
    pla_ctl_t ctl;
    logic     dmz;
    logic     nneg;
    logic     nzero;
  } pla_side_t;

  typedef struct packed {
    logic signed [OW-1:0] c;
    logic signed [OW-1:0] s;
  } pla_dir_t;

  typedef struct packed {
    logic [SQW-1:0] p11;
    logic [SQW-1:0] p10;
    logic [SQW-1:0] p01;
    logic [SQW-1:0] p00;
  } pla_pp_t;

  typedef struct packed {
    logic [PRW-1:0] lohi;
    logic [SQW:0]   mid;
  } pla_ps_t;

  function automatic pla_pp_t pla_parts(logic [SQW-1:0] a, logic [SQW-1:0] b);
    pla_pp_t r;
    r.p00 = a[FW-1:0] * b[FW-1:0];
    r.p01 = a[FW-1:0] * b[SQW-1:FW];
    r.p10 = a[SQW-1:FW] * b[FW-1:0];
    r.p11 = a[SQW-1:FW] * b[SQW-1:FW];
    return r;
  endfunction

  function automatic pla_ps_t pla_fold(pla_pp_t pp);
    pla_ps_t r;
    r.lohi = {pp.p11, pp.p00};
    r.mid  = {1'b0, pp.p01} + {1'b0, pp.p10};
    return r;
  endfunction

  // gain of the vectoring rotation applied to a unit vector at full scale
  function automatic logic [KW-1:0] cordic_gain_ref();
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    cx = longint'(1) << NORM_BITS;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
      end else begin
        cx = cx - dx;
        cy = cy + dy;
      end
    end
    return cx[KW-1:0];
  endfunction

  localparam logic [KW-1:0] KREF = cordic_gain_ref();

  function automatic logic signed [OW-1:0] pla_scale(logic sat, logic [QW-1:0] q, logic neg);
    logic signed [OW-1:0] m;
    if (sat || ({1'b0, q} > ONE_Q14)) m = ONE_Q14;
    else m = {1'b0, q};
    return neg ? -m : m;
  endfunction

endpackage

// ===== design/projectile_launch_angle_top.sv =====
// Launch angle solver: for each query (launch point, target point, speed) it
// returns whether the target is reachable under the programmed gravity and,
// if so, the unit direction (cos, sin in Q1.14) of the lower and the higher
// trajectory. A new query is taken every cycle while query_ready is high (low
// while the output spare entry is in use). Each answer passes through the
// discriminant (wide products built from 32x32 partial products), the square
// root (one result bit per stage), the numerator step, the direction units
// (normalize, rotation, multiply, division) and the output register. A two-entry
// output stage holds answers while answer_ready is low. Write gravity only while
// no query is in flight.
module projectile_launch_angle_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    query_valid,
  output logic                    query_ready,
  input  pla_pkg::pla_in_t        query,
  output logic                    answer_valid,
  input  logic                    answer_ready,
  output pla_pkg::pla_out_t       answer,
  input  logic                    gravity_we,
  input  logic [pla_pkg::FW-1:0]  gravity_wdata
);

  logic                    adv;
  logic                    full;
  logic [pla_pkg::FW-1:0]  gravity;

  pla_pkg::pla_ctl_t       ctl_d, ctl_q, ctl1, ctl2, plus_ctl, minus_ctl;
  logic [pla_pkg::EW-1:0]  e_d;
  logic [pla_pkg::SQW-1:0] s2_d, dm_d, s2_q, dm_q, dm1, dm2;
  logic [pla_pkg::RW-1:0]  r_q;

  logic [pla_pkg::NW-1:0]  np1, np2, nmag2;
  logic signed [pla_pkg::NW:0] nm1;
  logic                    nneg2, nzero2, pzero2;

  pla_pkg::pla_dir_t       plus_dir, minus_dir;
  pla_pkg::pla_out_t       item, spare;

  assign adv         = !full;
  assign query_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= pla_pkg::GRAVITY_RESET;
    end else if (gravity_we) begin
      gravity <= gravity_wdata;
    end
  end

  pla_disc u_disc (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .valid_in (query_valid),
    .query    (query),
    .gravity  (gravity),
    .ctl      (ctl_d),
    .e        (e_d),
    .s2       (s2_d),
    .dm       (dm_d)
  );

  pla_isqrt u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .ctl_in (ctl_d),
    .e      (e_d),
    .s2_in  (s2_d),
    .dm_in  (dm_d),
    .ctl    (ctl_q),
    .r      (r_q),
    .s2     (s2_q),
    .dm     (dm_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
    end else if (adv) begin
      // target to the left with a real divisor: plus root gives the lower angle
      ctl1 <= '{valid: ctl_q.valid, ok: ctl_q.ok, xneg: ctl_q.xneg,
                swap: ctl_q.xneg && (dm_q != '0)};
      ctl2 <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      np1    <= pla_pkg::NW'(s2_q) + pla_pkg::NW'(r_q);
      nm1    <= $signed({2'b00, s2_q}) - $signed({2'b00, r_q});
      dm1    <= dm_q;
      np2    <= np1;
      nmag2  <= nm1[pla_pkg::NW] ? pla_pkg::NW'(-nm1) : nm1[pla_pkg::NW-1:0];
      nneg2  <= nm1[pla_pkg::NW];
      nzero2 <= (nm1 == '0);
      pzero2 <= (np1 == '0);
      dm2    <= dm1;
    end
  end

  pla_dir u_dir_plus (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .ctl_in (ctl2),
    .dm     (dm2),
    .nmag   (np2),
    .nneg   (1'b0),
    .nzero  (pzero2),
    .ctl    (plus_ctl),
    .dir    (plus_dir)
  );

  pla_dir u_dir_minus (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .ctl_in (ctl2),
    .dm     (dm2),
    .nmag   (nmag2),
    .nneg   (nneg2),
    .nzero  (nzero2),
    .ctl    (minus_ctl),
    .dir    (minus_dir)
  );

  always_comb begin
    item = '0;
    if (plus_ctl.ok) begin
      item.reachable = 1'b1;
      if (plus_ctl.swap) begin
        item.low_cos  = plus_dir.c;
        item.low_sin  = plus_dir.s;
        item.high_cos = minus_dir.c;
        item.high_sin = minus_dir.s;
      end else begin
        item.low_cos  = minus_dir.c;
        item.low_sin  = minus_dir.s;
        item.high_cos = plus_dir.c;
        item.high_sin = plus_dir.s;
      end
    end
  end

  // output register plus one spare entry; the pipeline holds while spare is used
  always_ff @(posedge clk) begin
    if (rst) begin
      answer_valid <= 1'b0;
      full         <= 1'b0;
    end else if (full) begin
      if (answer_ready) begin
        full <= 1'b0;
      end
    end else if (!answer_valid || answer_ready) begin
      answer_valid <= plus_ctl.valid;
    end else if (plus_ctl.valid) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (full) begin
      if (answer_ready) begin
        answer <= spare;
      end
    end else if (!answer_valid || answer_ready) begin
      answer <= item;
    end else begin
      spare <= item;
    end
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    plus_ctl.valid == minus_ctl.valid && (!plus_ctl.valid || plus_ctl == minus_ctl))
    else $error("direction lanes out of step");

  a_spare_shown: assert property (@(posedge clk) disable iff (rst)
    full |-> answer_valid)
    else $error("spare entry used with empty output register");

  a_spare_hold: assert property (@(posedge clk) disable iff (rst)
    full && !answer_ready |=> full && answer_valid && $stable(answer))
    else $error("stalled answer not held");

  a_unreachable_zero: assert property (@(posedge clk) disable iff (rst)
    answer_valid && !answer.reachable |->
      answer.low_cos == '0 && answer.low_sin == '0 &&
      answer.high_cos == '0 && answer.high_sin == '0)
    else $error("unreachable answer carries a direction");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    answer_valid |->
      answer.low_cos <= pla_pkg::ONE_Q14 && answer.low_cos >= -pla_pkg::ONE_Q14 &&
      answer.high_sin <= pla_pkg::ONE_Q14 && answer.high_sin >= -pla_pkg::ONE_Q14)
    else $error("direction component beyond unit");

endmodule

// ===== design/pla_disc.sv =====
module pla_disc (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     valid_in,
  input  pla_pkg::pla_in_t         query,
  input  logic [pla_pkg::FW-1:0]   gravity,
  output pla_pkg::pla_ctl_t        ctl,
  output logic [pla_pkg::EW-1:0]   e,
  output logic [pla_pkg::SQW-1:0]  s2,
  output logic [pla_pkg::SQW-1:0]  dm
);

  logic [7:1] vld;

  logic [pla_pkg::DIFW-1:0] x1, y1;
  logic [pla_pkg::FW-1:0]   sp1;

  logic [pla_pkg::DIFW-1:0] xm2, ym2;
  logic [pla_pkg::FW-1:0]   sp2;
  logic                     xneg2, yneg2, spz2;

  logic [pla_pkg::SQW-1:0]  s2_3, gym3, gg3, xx3, dm3;
  logic                     xneg3, yneg3, spz3;

  pla_pkg::pla_pp_t         pa4, pb4, pc4;
  logic [pla_pkg::SQW-1:0]  s2_4, dm4;
  logic                     xneg4, yneg4, spz4;

  pla_pkg::pla_ps_t         fa5, fb5, fc5;
  logic [pla_pkg::SQW-1:0]  s2_5, dm5;
  logic                     xneg5, yneg5, spz5;

  logic [pla_pkg::PRW-1:0]  a6, b6, c6;
  logic [pla_pkg::SQW-1:0]  s2_6, dm6;
  logic                     xneg6, yneg6, spz6;

  logic [pla_pkg::EW-1:0]   e7, c7;
  logic [pla_pkg::SQW-1:0]  s2_7, dm7;
  logic                     xneg7, spz7;

  logic [pla_pkg::EW-1:0]   e_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      ctl <= '0;
    end else if (adv) begin
      vld <= {vld[6:1], valid_in};
      ctl <= '{valid: vld[7], ok: !spz7 && !e_next[pla_pkg::EW-1], xneg: xneg7,
               swap: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1  <= {query.to_x[pla_pkg::FW-1], query.to_x} - {query.from_x[pla_pkg::FW-1], query.from_x};
      y1  <= {query.to_y[pla_pkg::FW-1], query.to_y} - {query.from_y[pla_pkg::FW-1], query.from_y};
      sp1 <= query.launch_speed;

      xm2   <= x1[pla_pkg::DIFW-1] ? pla_pkg::DIFW'(-x1) : x1;
      ym2   <= y1[pla_pkg::DIFW-1] ? pla_pkg::DIFW'(-y1) : y1;
      xneg2 <= x1[pla_pkg::DIFW-1];
      yneg2 <= y1[pla_pkg::DIFW-1];
      sp2   <= sp1;
      spz2  <= (sp1 == '0);

      s2_3  <= sp2 * sp2;
      gym3  <= gravity * ym2;
      gg3   <= gravity * gravity;
      xx3   <= xm2 * xm2;
      dm3   <= gravity * xm2;
      xneg3 <= xneg2;
      yneg3 <= yneg2;
      spz3  <= spz2;

      pa4   <= pla_pkg::pla_parts(s2_3, s2_3);
      pb4   <= pla_pkg::pla_parts(gym3, s2_3);
      pc4   <= pla_pkg::pla_parts(gg3, xx3);
      s2_4  <= s2_3;
      dm4   <= dm3;
      xneg4 <= xneg3;
      yneg4 <= yneg3;
      spz4  <= spz3;

      fa5   <= pla_pkg::pla_fold(pa4);
      fb5   <= pla_pkg::pla_fold(pb4);
      fc5   <= pla_pkg::pla_fold(pc4);
      s2_5  <= s2_4;
      dm5   <= dm4;
      xneg5 <= xneg4;
      yneg5 <= yneg4;
      spz5  <= spz4;

      a6    <= fa5.lohi + (pla_pkg::PRW'(fa5.mid) << pla_pkg::FW);
      b6    <= fb5.lohi + (pla_pkg::PRW'(fb5.mid) << pla_pkg::FW);
      c6    <= fc5.lohi + (pla_pkg::PRW'(fc5.mid) << pla_pkg::FW);
      s2_6  <= s2_5;
      dm6   <= dm5;
      xneg6 <= xneg5;
      yneg6 <= yneg5;
      spz6  <= spz5;

      // below the launch point the gravity term adds
      e7    <= yneg6 ? pla_pkg::EW'(a6) + (pla_pkg::EW'(b6) << 1)
                     : pla_pkg::EW'(a6) - (pla_pkg::EW'(b6) << 1);
      c7    <= pla_pkg::EW'(c6);
      s2_7  <= s2_6;
      dm7   <= dm6;
      xneg7 <= xneg6;
      spz7  <= spz6;

      e        <= e_next;
      s2       <= s2_7;
      dm       <= dm7;
    end
  end

  assign e_next = e7 - c7;

endmodule

// ===== design/pla_isqrt.sv =====
module pla_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  pla_pkg::pla_ctl_t        ctl_in,
  input  logic [pla_pkg::EW-1:0]   e,
  input  logic [pla_pkg::SQW-1:0]  s2_in,
  input  logic [pla_pkg::SQW-1:0]  dm_in,
  output pla_pkg::pla_ctl_t        ctl,
  output logic [pla_pkg::RW-1:0]   r,
  output logic [pla_pkg::SQW-1:0]  s2,
  output logic [pla_pkg::SQW-1:0]  dm
);

  localparam int N = pla_pkg::SQ_STEPS;

  pla_pkg::pla_ctl_t       cs  [N+1];
  logic [pla_pkg::EW-1:0]  rem [N+1];
  logic [pla_pkg::EW-1:0]  res [N+1];
  logic [pla_pkg::SQW-1:0] s2a [N+1];
  logic [pla_pkg::SQW-1:0] dma [N+1];

  assign cs[0]  = ctl_in;
  assign rem[0] = e;
  assign res[0] = '0;
  assign s2a[0] = s2_in;
  assign dma[0] = dm_in;

  // one result bit per stage, trial bit moving down two places each time
  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [pla_pkg::EW-1:0] BIT =
      {{(pla_pkg::EW-1){1'b0}}, 1'b1} << (pla_pkg::EW - 1 - 2 * j);
    logic [pla_pkg::EW-1:0] t;
    logic                   take;

    assign t    = res[j] | BIT;
    assign take = rem[j] >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        cs[j+1].valid <= 1'b0;
      end else if (adv) begin
        cs[j+1] <= cs[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j+1] <= take ? rem[j] - t : rem[j];
        res[j+1] <= take ? (res[j] >> 1) + BIT : res[j] >> 1;
        s2a[j+1] <= s2a[j];
        dma[j+1] <= dma[j];
      end
    end
  end

  assign ctl = cs[N];
  assign r   = res[N][pla_pkg::RW-1:0];
  assign s2  = s2a[N];
  assign dm  = dma[N];

endmodule

// ===== design/pla_div.sv =====
module pla_div (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [pla_pkg::PW-1:0]  p,
  input  logic [pla_pkg::MW-1:0]  mag,
  output logic                    sat,
  output logic [pla_pkg::QW-1:0]  q
);

  localparam int N = pla_pkg::QW;

  logic [pla_pkg::DVW-1:0] n0, dd0;
  logic [pla_pkg::DVW-1:0] rem [N];
  logic [pla_pkg::DVW-1:0] dd  [N];
  logic [pla_pkg::QW-1:0]  qq  [N+1];
  logic                    st  [N+1];

  // rounded quotient: (2p + d) / 2d with d = mag scaled up
  always_ff @(posedge clk) begin
    if (adv) begin
      n0  <= (pla_pkg::DVW'(p) << 1) + (pla_pkg::DVW'(mag) << pla_pkg::DIV_SHIFT);
      dd0 <= pla_pkg::DVW'(mag) << (pla_pkg::DIV_SHIFT + 1);
      rem[0] <= n0;
      dd[0]  <= dd0;
      qq[0]  <= '0;
      st[0]  <= n0 >= (dd0 << N);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int POS = N - 1 - k;
    logic [pla_pkg::DVW-1:0] sh;
    logic                    take;

    assign sh   = dd[k] << POS;
    assign take = rem[k] >= sh;

    always_ff @(posedge clk) begin
      if (adv) begin
        qq[k+1] <= qq[k] | (pla_pkg::QW'(take) << POS);
        st[k+1] <= st[k];
      end
    end

    if (k < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[k+1] <= take ? rem[k] - sh : rem[k];
          dd[k+1]  <= dd[k];
        end
      end
    end
  end

  assign sat = st[N];
  assign q   = qq[N];

endmodule

// ===== design/pla_dir.sv =====
module pla_dir (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  pla_pkg::pla_ctl_t        ctl_in,
  input  logic [pla_pkg::SQW-1:0]  dm,
  input  logic [pla_pkg::NW-1:0]   nmag,
  input  logic                     nneg,
  input  logic                     nzero,
  output pla_pkg::pla_ctl_t        ctl,
  output pla_pkg::pla_dir_t        dir
);

  localparam int NS = pla_pkg::NORM_STEPS;
  localparam int CS = pla_pkg::CORDIC_STEPS;
  localparam int SL = pla_pkg::SIDE_LAT;

  pla_pkg::pla_side_t sd [SL+1];

  logic [pla_pkg::NW-1:0]        na [NS+1];
  logic [pla_pkg::NW-1:0]        nb [NS+1];
  logic signed [pla_pkg::CW-1:0] cx [CS+1];
  logic signed [pla_pkg::CW-1:0] cy [CS+1];
  logic [pla_pkg::NORM_BITS-1:0] ca [CS+1];
  logic [pla_pkg::NORM_BITS-1:0] cb [CS+1];

  logic [pla_pkg::PW-1:0]  pa, pb;
  logic [pla_pkg::MW-1:0]  mag;
  logic                    sat_c, sat_s;
  logic [pla_pkg::QW-1:0]  q_c, q_s;
  pla_pkg::pla_dir_t       dir_next;
  pla_pkg::pla_side_t      last;

  assign sd[0].ctl   = ctl_in;
  assign sd[0].dmz   = (dm == '0);
  assign sd[0].nneg  = nneg;
  assign sd[0].nzero = nzero;

  for (genvar k = 0; k < SL; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[k+1].ctl.valid <= 1'b0;
      end else if (adv) begin
        sd[k+1] <= sd[k];
      end
    end
  end

  assign na[0] = pla_pkg::NW'(dm);
  assign nb[0] = nmag;

  // shift both together until each fits the rotation range
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int AMT = 1 << (NS - 1 - k);
    logic big;

    assign big = ((na[k] | nb[k]) >> (pla_pkg::NORM_BITS - 1 + AMT)) != '0;

    always_ff @(posedge clk) begin
      if (adv) begin
        na[k+1] <= big ? na[k] >> AMT : na[k];
        nb[k+1] <= big ? nb[k] >> AMT : nb[k];
      end
    end
  end

  assign ca[0] = na[NS][pla_pkg::NORM_BITS-1:0];
  assign cb[0] = nb[NS][pla_pkg::NORM_BITS-1:0];
  assign cx[0] = $signed({{(pla_pkg::CW-pla_pkg::NORM_BITS){1'b0}}, ca[0]});
  assign cy[0] = $signed({{(pla_pkg::CW-pla_pkg::NORM_BITS){1'b0}}, cb[0]});

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [pla_pkg::CW-1:0] dx, dy;

    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cy[i][pla_pkg::CW-1]) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
        end
        ca[i+1] <= ca[i];
        cb[i+1] <= cb[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa  <= pla_pkg::PW'(ca[CS]) * pla_pkg::PW'(pla_pkg::KREF);
      pb  <= pla_pkg::PW'(cb[CS]) * pla_pkg::PW'(pla_pkg::KREF);
      mag <= cx[CS][pla_pkg::MW-1:0];
    end
  end

  pla_div u_div_c (
    .clk (clk),
    .adv (adv),
    .p   (pa),
    .mag (mag),
    .sat (sat_c),
    .q   (q_c)
  );

  pla_div u_div_s (
    .clk (clk),
    .adv (adv),
    .p   (pb),
    .mag (mag),
    .sat (sat_s),
    .q   (q_s)
  );

  assign last = sd[SL];

  always_comb begin
    dir_next.c = pla_pkg::pla_scale(sat_c, q_c, last.ctl.xneg);
    dir_next.s = pla_pkg::pla_scale(sat_s, q_s, last.nneg);
    // vertical shot: straight up, down, or flat when nothing to aim at
    if (last.dmz) begin
      dir_next.c = last.nzero ? pla_pkg::ONE_Q14 : '0;
      dir_next.s = last.nzero ? '0 : (last.nneg ? -pla_pkg::ONE_Q14 : pla_pkg::ONE_Q14);
      if (last.ctl.xneg) begin
        dir_next.c = -dir_next.c;
        dir_next.s = -dir_next.s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl <= last.ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir <= dir_next;
    end
  end

endmodule

// ===== verif/projectile_launch_angle_top_test.sv =====
module projectile_launch_angle_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pla_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam logic [191:0] NORM_TOP = 192'd1 << 30;

  logic clk;
  logic rst;
  logic query_valid;
  logic query_ready;
  pla_in_t query;
  logic answer_valid;
  logic answer_ready;
  pla_out_t answer;
  logic gravity_we;
  logic [FW-1:0] gravity_wdata;

  pla_in_t pending_queries[$];
  pla_out_t expected_answers[$];
  logic [31:0] gravity_now;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_queries;
  int mismatches;
  int stall_cycles;

  projectile_launch_angle_top uut (
    .clk(clk), .rst(rst),
    .query_valid(query_valid), .query_ready(query_ready), .query(query),
    .answer_valid(answer_valid), .answer_ready(answer_ready), .answer(answer),
    .gravity_we(gravity_we), .gravity_wdata(gravity_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [191:0] wide_mul(logic [63:0] a, logic [63:0] b);
    logic [191:0] aa;
    logic [191:0] bb;
    aa = a;
    bb = b;
    return aa * bb;
  endfunction

  function automatic logic [191:0] floor_sqrt(logic [191:0] v);
    logic [191:0] root;
    logic [191:0] bitv;
    logic [191:0] t;
    root = '0;
    bitv = 192'd1 << 130;
    while (bitv != 0) begin
      t = root + bitv;
      if (v >= t) begin
        v = v - t;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint rotate_mag(longint cx, longint cy);
    longint dx;
    longint dy;
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
      end else begin
        cx = cx - dx;
        cy = cy + dy;
      end
    end
    return cx;
  endfunction

  function automatic logic signed [15:0] unit_comp(longint unsigned m, longint unsigned kref,
                                                   longint unsigned mag, bit neg);
    longint unsigned p;
    longint unsigned d;
    longint unsigned qv;
    p = m * kref;
    d = mag << 16;
    qv = (2 * p + d) / (2 * d);
    if (qv > 16384) qv = 16384;
    return neg ? -16'(qv) : 16'(qv);
  endfunction

  function automatic pla_dir_t unit_direction(logic [63:0] dm, bit xneg, logic [191:0] n);
    pla_dir_t r;
    bit nneg;
    logic [191:0] a;
    logic [191:0] b;
    longint kref;
    longint mag;
    nneg = n[191];
    r = '0;
    if (dm == 0) begin
      // vertical shot: straight up, straight down, or flat for 0/0
      if (n == 0) r.c = ONE_Q14;
      else r.s = nneg ? -ONE_Q14 : ONE_Q14;
      if (xneg) begin
        r.c = -r.c;
        r.s = -r.s;
      end
      return r;
    end
    a = dm;
    b = nneg ? -n : n;
    while (a >= NORM_TOP || b >= NORM_TOP) begin
      a = a >> 1;
      b = b >> 1;
    end
    kref = rotate_mag(longint'(1) << 30, 0);
    mag = rotate_mag(longint'(a[63:0]), longint'(b[63:0]));
    r.c = unit_comp(a[63:0], kref, mag, xneg);
    r.s = unit_comp(b[63:0], kref, mag, nneg);
    return r;
  endfunction

  function automatic pla_out_t predict_answer(pla_in_t q, logic [31:0] g);
    pla_out_t res;
    longint x;
    longint y;
    bit xneg;
    logic [63:0] xm;
    logic [63:0] ym;
    logic [63:0] sp;
    logic [63:0] g64;
    logic [63:0] s2;
    logic [63:0] dm;
    logic [63:0] gym;
    logic [63:0] gg;
    logic [63:0] xx;
    logic [191:0] disc;
    logic [191:0] gy;
    logic [191:0] root;
    pla_dir_t plus_dir;
    pla_dir_t minus_dir;
    res = '0;
    x = longint'(q.to_x) - longint'(q.from_x);
    y = longint'(q.to_y) - longint'(q.from_y);
    if (q.launch_speed == 0) return res;
    xneg = x < 0;
    xm = xneg ? -x : x;
    ym = (y < 0) ? -y : y;
    sp = q.launch_speed;
    g64 = g;
    s2 = sp * sp;
    // products below wrap at 64 bits, as in the fixed-point datapath
    gym = g64 * ym;
    gg = g64 * g64;
    xx = xm * xm;
    disc = wide_mul(s2, s2);
    gy = wide_mul(gym, s2) << 1;
    disc = (y < 0) ? disc + gy : disc - gy;
    disc = disc - wide_mul(gg, xx);
    if (disc[191]) return res;
    root = floor_sqrt(disc);
    dm = g64 * xm;
    plus_dir = unit_direction(dm, xneg, {128'd0, s2} + root);
    minus_dir = unit_direction(dm, xneg, {128'd0, s2} - root);
    res.reachable = 1'b1;
    if (xneg && dm != 0) begin
      res.low_cos = plus_dir.c;
      res.low_sin = plus_dir.s;
      res.high_cos = minus_dir.c;
      res.high_sin = minus_dir.s;
    end else begin
      res.low_cos = minus_dir.c;
      res.low_sin = minus_dir.s;
      res.high_cos = plus_dir.c;
      res.high_sin = plus_dir.s;
    end
    return res;
  endfunction

  // driver: take a new transaction when the slot is free
  always @(posedge clk) begin
    if (rst) begin
      query_valid <= 1'b0;
    end else begin
      if (query_valid && query_ready)
        expected_answers.push_back(predict_answer(query, gravity_now));
      if (!query_valid || query_ready) begin
        if (!hold_queries && pending_queries.size() > 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          query <= pending_queries.pop_front();
          query_valid <= 1'b1;
        end else begin
          query_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pla_out_t exp_ans;
    if (rst) begin
      answer_ready <= 1'b0;
    end else begin
      answer_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (answer_valid && answer_ready) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected answer %h", answer);
        end else begin
          exp_ans = expected_answers.pop_front();
          if (answer.reachable !== exp_ans.reachable || answer.low_cos !== exp_ans.low_cos ||
              answer.low_sin !== exp_ans.low_sin || answer.high_cos !== exp_ans.high_cos ||
              answer.high_sin !== exp_ans.high_sin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected r=%0d lo=(%0d,%0d) hi=(%0d,%0d) got r=%0d lo=(%0d,%0d) hi=(%0d,%0d)",
                       exp_ans.reachable, exp_ans.low_cos, exp_ans.low_sin, exp_ans.high_cos,
                       exp_ans.high_sin, answer.reachable, answer.low_cos, answer.low_sin,
                       answer.high_cos, answer.high_sin);
          end
        end
      end
    end
  end

  // watchdog: count only cycles where work is outstanding and nothing moves
  always @(posedge clk) begin
    if (rst || (query_valid && query_ready) || (answer_valid && answer_ready) ||
        (expected_answers.size() == 0 && !query_valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("projectile_launch_angle_top test failed");
        $finish;
      end
    end
  end

  task automatic add_query(longint fx, longint fy, longint tx, longint ty, longint sp);
    pla_in_t q;
    q.from_x = fx[31:0];
    q.from_y = fy[31:0];
    q.to_x = tx[31:0];
    q.to_y = ty[31:0];
    q.launch_speed = sp[31:0];
    pending_queries.push_back(q);
  endtask

  task automatic add_random_query();
    pla_in_t q;
    longint sp;
    longint lim;
    longint fx;
    longint fy;
    longint dx;
    longint dy;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      q = {$urandom, $urandom, $urandom, $urandom, $urandom};
      pending_queries.push_back(q);
      return;
    end
    sp = ($urandom_range(9) == 0) ? longint'($urandom) : longint'($urandom_range(1, 1 << 24));
    if (sp == 0) sp = 1;
    lim = (sp * sp) / longint'(gravity_now);
    if (lim > (1 << 30)) lim = 1 << 30;
    if (lim < 1) lim = 1;
    dx = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    dy = longint'($urandom_range(0, 32'(lim + lim / 2))) - lim;
    if (pick < 25) begin
      // broken: overshoot in range or zero speed
      dx = dx * 3 + ((dx < 0) ? -lim : lim);
      if (dx > (1 << 30)) dx = 1 << 30;
      if (dx < -(1 << 30)) dx = -(1 << 30);
      if ($urandom_range(4) == 0) sp = 0;
    end else if (pick < 30) begin
      dx = 0;
    end
    fx = longint'($urandom_range(0, 32'h3fffffff)) - (1 << 29);
    fy = longint'($urandom_range(0, 32'h3fffffff)) - (1 << 29);
    add_query(fx, fy, fx + dx, fy + dy, sp);
  endtask

  task automatic wait_idle();
    while (pending_queries.size() > 0 || query_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gravity(logic [31:0] value);
    @(posedge clk);
    gravity_we <= 1'b1;
    gravity_wdata <= value;
    gravity_now = value;
    @(posedge clk);
    gravity_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] phase_gravity[6];
    rst = 1'b1;
    query_valid = 1'b0;
    query = '0;
    answer_ready = 1'b0;
    gravity_we = 1'b0;
    gravity_wdata = '0;
    gravity_now = GRAVITY_RESET;
    send_idle_pct = 11;
    recv_idle_pct = 84;
    hold_queries = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    phase_gravity[0] = GRAVITY_RESET;
    phase_gravity[1] = 32'd1;
    phase_gravity[2] = 32'hffffffff;
    phase_gravity[3] = $urandom_range(1, 32'hffffffff);
    phase_gravity[4] = GRAVITY_RESET;
    phase_gravity[5] = $urandom_range(32768, 4000000);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed cases under reset gravity
    add_query(0, 0, 0, 0, 0);
    add_query(0, 0, 0, 0, 1);
    add_query(0, 0, 0, 0, 32'hffffffff);
    add_query(0, 0, 0, 1 << 20, 1 << 22);
    add_query(0, 0, 0, -(1 << 20), 1 << 22);
    add_query(0, 0, 642253, 0, 642253);
    add_query(0, 0, -642253, 0, 642253);
    add_query(0, 0, 100 << 16, 0, 40 << 16);
    add_query(0, 0, -(100 << 16), 0, 40 << 16);
    add_query(0, 0, 5 << 16, 2 << 16, 20 << 16);
    add_query(0, 0, -(5 << 16), -(2 << 16), 20 << 16);
    add_query(0, 0, 1, 0, 32'hffffffff);
    add_query(-2147483648, -2147483648, 2147483647, 2147483647, 32'hffffffff);
    add_query(2147483647, 2147483647, -2147483648, -2147483648, 32'hffffffff);
    add_query(2147483647, -2147483648, -2147483648, 2147483647, 1);
    add_query(0, 0, 2147483647, -2147483648, 1 << 16);
    add_query(-2147483648, 2147483647, 0, 0, 32'h80000000);
    add_query(0, 0, 3 << 16, 0, 1);
    add_query(0, 0, 0, 2147483647, 32'hffffffff);
    add_query(0, 0, 0, -2147483648, 32'hffffffff);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_gravity(phase_gravity[ph]);
      end
      send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 84 : 0;
      recv_idle_pct = (ph < 2) ? 84 : (ph < 4) ? 11 : 0;
      for (int i = 0; i < 172; i++) add_random_query();
      if (ph == 4) begin
        // hold off the sender until the pipeline empties
        while (pending_queries.size() > 100) @(posedge clk);
        hold_queries = 1'b1;
        while (query_valid || expected_answers.size() > 0) @(posedge clk);
        hold_queries = 1'b0;
      end
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("projectile_launch_angle_top test passed");
    end else begin
      $display("projectile_launch_angle_top test failed");
    end
    $finish;
  end
endmodule
